// ===== design/sbr_pkg.sv =====
// shared types, sizes and helpers for the stream byte reassembler
// no dependencies; imported by sbr_ctrl, sbr_dp and stream_byte_reassembler
`default_nettype none

package sbr_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [BYTE_W-1:0] byte_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic scan;
        logic fetch;
        logic show;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mode_one;
        logic scan_more;
        logic cnt_zero;
    } stat_t;

    function automatic slot_t slot_inc(input slot_t s);
        slot_t r;
        if (s == slot_t'(CAPACITY - 1))
        begin
            r = '0;
        end
        else
        begin
            r = s + slot_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/sbr_ctrl.sv =====
// sequencer for the reassembler: capture, update, head scan, byte drain
// depends on sbr_pkg; drives the datapath sbr_dp through cmd_t / stat_t
`default_nettype none

module sbr_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic               m_tuser,
    output logic               m_tlast,
    output sbr_pkg::cmd_t      cmd,
    input  wire sbr_pkg::stat_t stat
);
    import sbr_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        UPDATE,
        SCAN,
        FETCH,
        SHOW,
        NONE
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;
    logic   m_tvalid_reg;
    logic   m_tuser_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = UPDATE;
                end
            end
            UPDATE:
            begin
                state_next = stat.mode_one ? NONE : SCAN;
            end
            SCAN:
            begin
                if (!stat.scan_more)
                begin
                    state_next = stat.cnt_zero ? NONE : FETCH;
                end
            end
            FETCH:
            begin
                state_next = SHOW;
            end
            SHOW:
            begin
                if (m_tready)
                begin
                    state_next = stat.cnt_zero ? IDLE : FETCH;
                end
            end
            NONE:
            begin
                if (m_tready)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == IDLE);
            m_tvalid_reg <= (state_next == SHOW) || (state_next == NONE);
            m_tuser_reg  <= (state_next == SHOW);
        end
    end

    assign cmd.capture = (state_reg == IDLE) && s_tvalid;
    assign cmd.update  = (state_reg == UPDATE);
    assign cmd.scan    = (state_reg == SCAN);
    assign cmd.fetch   = (state_reg == FETCH);
    assign cmd.show    = m_tuser_reg;

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    // a drained word is last once the run count is used up; the no-byte word is always last
    assign m_tlast  = m_tvalid_reg && (!m_tuser_reg || stat.cnt_zero);

endmodule

`default_nettype wire

// ===== design/sbr_dp.sv =====
// datapath of the reassembler: window memory, valid marks, stream counters
// depends on sbr_pkg; sequenced by sbr_ctrl
`default_nettype none

module sbr_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sbr_pkg::cmd_t  cmd,
    output sbr_pkg::stat_t      stat,
    input  wire logic           mode,
    input  wire sbr_pkg::idx_t  byte_index,
    input  wire sbr_pkg::byte_t byte_value,
    input  wire logic           has_byte,
    input  wire logic           last_of_segment,
    input  wire logic           eof_flag,
    input  wire sbr_pkg::cnt_t  read_count,
    output sbr_pkg::byte_t      out_byte,
    output logic                end_of_stream,
    output sbr_pkg::cnt_t       unassembled_count
);
    import sbr_pkg::*;

    localparam logic [IDX_W:0]    CAP_EXT  = (IDX_W + 1)'(CAPACITY);
    localparam logic [SLOT_W:0]   CAP_SLOT = (SLOT_W + 1)'(CAPACITY);

    // captured word
    logic  mode_reg;
    idx_t  idx_reg;
    byte_t val_reg;
    logic  has_reg;
    logic  last_reg;
    logic  eof_reg;
    cnt_t  rc_reg;

    // stream state
    byte_t                 mem [CAPACITY];
    logic [CAPACITY-1:0]   valid_reg;
    idx_t                  wt_reg;
    slot_t                 wt_slot_reg;
    idx_t                  rt_reg;
    logic                  eof_seen_reg;
    cnt_t                  held_reg;

    // head scan
    idx_t  scan_idx_reg;
    slot_t scan_slot_reg;
    cnt_t  cnt_reg;
    byte_t rd_data_reg;

    logic [IDX_W:0]  limit;
    logic [IDX_W:0]  seg_end;
    idx_t            offset;
    logic [SLOT_W:0] slot_sum;
    slot_t           st_slot;
    logic            store;
    logic            eof_hit;
    logic [IDX_W:0]  rt_sum;

    always_comb
    begin
        limit    = {1'b0, rt_reg} + CAP_EXT;
        seg_end  = {1'b0, idx_reg} + {{IDX_W{1'b0}}, has_reg};
        offset   = idx_reg - wt_reg;
        // offset stays below CAPACITY whenever the byte is stored
        slot_sum = {1'b0, wt_slot_reg} + {1'b0, offset[SLOT_W-1:0]};
        st_slot  = (slot_sum >= CAP_SLOT) ? slot_t'(slot_sum - CAP_SLOT)
                                          : slot_sum[SLOT_W-1:0];
        store    = has_reg && (idx_reg >= wt_reg) && ({1'b0, idx_reg} < limit)
                   && (idx_reg != '1);
        eof_hit  = last_reg && eof_reg && (seg_end <= limit);
        rt_sum   = {1'b0, rt_reg} + (IDX_W + 1)'(rc_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            idx_reg  <= byte_index;
            val_reg  <= byte_value;
            has_reg  <= has_byte;
            last_reg <= last_of_segment;
            eof_reg  <= eof_flag;
            rc_reg   <= read_count;
        end
        if (cmd.update && !mode_reg && store)
        begin
            mem[st_slot] <= val_reg;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[wt_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            wt_reg        <= '0;
            wt_slot_reg   <= '0;
            rt_reg        <= '0;
            eof_seen_reg  <= 1'b0;
            held_reg      <= '0;
            scan_idx_reg  <= '0;
            scan_slot_reg <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.update)
            begin
                scan_idx_reg  <= wt_reg;
                scan_slot_reg <= wt_slot_reg;
                cnt_reg       <= '0;
                if (mode_reg)
                begin
                    rt_reg <= (rt_sum > {1'b0, wt_reg}) ? wt_reg : rt_sum[IDX_W-1:0];
                end
                else
                begin
                    if (eof_hit)
                    begin
                        eof_seen_reg <= 1'b1;
                    end
                    if (store)
                    begin
                        valid_reg[st_slot] <= 1'b1;
                        if (!valid_reg[st_slot])
                        begin
                            held_reg <= held_reg + cnt_t'(1);
                        end
                    end
                end
            end
            if (cmd.scan)
            begin
                if (stat.scan_more)
                begin
                    scan_idx_reg  <= scan_idx_reg + idx_t'(1);
                    scan_slot_reg <= slot_inc(scan_slot_reg);
                    cnt_reg       <= cnt_reg + cnt_t'(1);
                end
                else
                begin
                    // the whole run leaves the window
                    held_reg <= held_reg - cnt_reg;
                end
            end
            if (cmd.fetch)
            begin
                valid_reg[wt_slot_reg] <= 1'b0;
                wt_reg                 <= wt_reg + idx_t'(1);
                wt_slot_reg            <= slot_inc(wt_slot_reg);
                cnt_reg                <= cnt_reg - cnt_t'(1);
            end
        end
    end

    assign stat.mode_one  = mode_reg;
    assign stat.scan_more = valid_reg[scan_slot_reg] && (scan_idx_reg != '1)
                            && (cnt_reg != cnt_t'(CAPACITY));
    assign stat.cnt_zero  = (cnt_reg == '0);

    assign out_byte          = cmd.show ? rd_data_reg : '0;
    assign end_of_stream     = eof_seen_reg && (held_reg == '0);
    assign unassembled_count = held_reg;

endmodule

`default_nettype wire

// ===== design/stream_byte_reassembler.sv =====
// channel  dir  signals                    payload
// s_       in   tvalid tready tdata tuser  one segment byte or consumer read notice
//                      tlast               last word of the segment
// m_       out  tvalid tready tdata tuser  one delivered byte or a status-only word
//                      tlast               last word caused by the input word
//
// one word at a time: capture, an update step, a head scan of one slot per
// cycle, then a memory read and an output word for each delivered byte; a
// segment word that releases nothing and a read notice each give one
// status-only word.
// rst_n is asynchronous; valid marks and counters clear at once, no sweep.
// the sink may hold m_tready low at any time; the output word holds meanwhile.
//
// top level of the stream byte reassembler; depends on sbr_pkg, sbr_ctrl, sbr_dp
`default_nettype none

module stream_byte_reassembler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // byte_index[31:0], byte_value[39:32], eof_flag[40], read_count[47:41]
    input  wire logic [sbr_pkg::IN_DATA_W-1:0] s_tdata,
    // mode[0], has_byte[1]
    input  wire logic [sbr_pkg::IN_USER_W-1:0] s_tuser,
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // out_byte[7:0], end_of_stream[8], unassembled_count[15:9]
    output logic [sbr_pkg::OUT_DATA_W-1:0]    m_tdata,
    // out_valid[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import sbr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    byte_t out_byte;
    logic  end_of_stream;
    cnt_t  unassembled_count;

    sbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

    sbr_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .mode              (s_tuser[0]),
        .byte_index        (s_tdata[IDX_W-1:0]),
        .byte_value        (s_tdata[IDX_W+BYTE_W-1:IDX_W]),
        .has_byte          (s_tuser[1]),
        .last_of_segment   (s_tlast),
        .eof_flag          (s_tdata[IDX_W+BYTE_W]),
        .read_count        (s_tdata[IDX_W+BYTE_W+CNT_W:IDX_W+BYTE_W+1]),
        .out_byte          (out_byte),
        .end_of_stream     (end_of_stream),
        .unassembled_count (unassembled_count)
    );

    assign m_tdata = {unassembled_count, end_of_stream, out_byte};

    // one word in flight: never taking input while a result is offered
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after an accepted word");

    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0 && m_tlast))
        else $error("status-only word carries a byte or is not last");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (unassembled_count <= cnt_t'(CAPACITY)))
        else $error("held count beyond window size");

endmodule

`default_nettype wire

// ===== verif/stream_byte_reassembler_tb.sv =====
// self-checking testbench for stream_byte_reassembler: directed corner words, then random
// out-of-order segments with consumer reads, checked against an in-bench reassembly model
// depends on sbr_pkg and the stream_byte_reassembler rtl
`timescale 1ns / 100ps

module stream_byte_reassembler_tb;

    import sbr_pkg::*;

    typedef enum bit {MODE_SEG = 1'b0, MODE_READ = 1'b1} mode_e;

    typedef struct {
        mode_e mode;
        idx_t  index;
        byte_t value;
        bit    has_byte;
        bit    seg_last;
        bit    eof;
        cnt_t  read_count;
        bit    drain_first;
    } in_word_t;

    typedef struct {
        bit    valid;
        byte_t data;
        bit    eos;
        cnt_t  held;
        bit    last;
    } out_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // byte_index[31:0], byte_value[39:32], eof_flag[40], read_count[47:41]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // mode[0], has_byte[1]
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // out_byte[7:0], end_of_stream[8], unassembled_count[15:9]
    logic [OUT_DATA_W-1:0] m_tdata;
    // out_valid[0]
    logic                  m_tuser;
    logic                  m_tlast;

    in_word_t  stim_q[$];
    out_word_t reassembled_q[$];
    in_word_t  cur_word;
    int        planned = 0;
    bit        drain_next = 1'b0;
    int        fault_count = 0;
    int        sent_count = 0;
    int        got_count = 0;
    int        src_wait = 0;
    int        sink_wait = 0;
    bit        src_calm = 1'b0;
    bit        sink_calm = 1'b0;

    // reassembly state mirrored in the bench
    byte_t byte_mem [CAPACITY];
    bit    slot_full [CAPACITY] = '{default: 1'b0};
    idx_t  write_pt = '0;
    idx_t  read_pt = '0;
    bit    eof_latched = 1'b0;
    cnt_t  held = '0;

    stream_byte_reassembler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic int draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // queue one input word; fields the block ignores in this mode get random values
    function automatic void push_word(input mode_e mode, input idx_t index, input int value,
                                      input bit has_byte, input bit seg_last, input bit eof,
                                      input int read_count);
        in_word_t w;
        w.mode        = mode;
        w.index       = index;
        w.value       = byte_t'(value);
        w.has_byte    = has_byte;
        w.seg_last    = seg_last;
        w.eof         = eof;
        w.read_count  = cnt_t'(read_count);
        w.drain_first = drain_next;
        if (mode == MODE_READ)
        begin
            w.index    = $urandom;
            w.value    = byte_t'($urandom_range(0, 255));
            w.has_byte = bit'($urandom_range(0, 1));
            w.seg_last = bit'($urandom_range(0, 1));
            w.eof      = bit'($urandom_range(0, 1));
        end
        else
        begin
            w.read_count = cnt_t'($urandom_range(0, 64));
        end
        drain_next = 1'b0;
        stim_q.insert(stim_q.size(), w);
        planned++;
    endfunction

    // apply one accepted word and queue the words the block must send for it
    function automatic void reassemble(input in_word_t w);
        logic [IDX_W:0] limit;
        logic [IDX_W:0] seg_end;
        logic [IDX_W:0] rd_next;
        int             slot;
        out_word_t      r;
        out_word_t      burst[$];
        limit = {1'b0, read_pt} + CAPACITY;
        if (w.mode == MODE_READ)
        begin
            rd_next = {1'b0, read_pt} + w.read_count;
            read_pt = (rd_next > {1'b0, write_pt}) ? write_pt : rd_next[IDX_W-1:0];
        end
        else
        begin
            if (w.seg_last && w.eof)
            begin
                // end index may be 2^32, so compare one bit wider
                seg_end = {1'b0, w.index} + w.has_byte;
                if (seg_end <= limit)
                    eof_latched = 1'b1;
            end
            if (w.has_byte && w.index >= write_pt && {1'b0, w.index} < limit &&
                w.index != '1)
            begin
                slot = w.index % CAPACITY;
                if (!slot_full[slot])
                begin
                    slot_full[slot] = 1'b1;
                    held++;
                end
                byte_mem[slot] = w.value;
            end
            while (burst.size() < CAPACITY && write_pt != '1)
            begin
                slot = write_pt % CAPACITY;
                if (!slot_full[slot])
                    break;
                r.valid = 1'b1;
                r.data  = byte_mem[slot];
                burst.insert(burst.size(), r);
                slot_full[slot] = 1'b0;
                write_pt++;
                if (held != 0)
                    held--;
            end
        end
        if (burst.size() == 0)
        begin
            r.valid = 1'b0;
            r.data  = '0;
            burst.insert(burst.size(), r);
        end
        foreach (burst[k])
        begin
            r      = burst[k];
            r.eos  = eof_latched && (held == 0);
            r.held = held;
            r.last = (k == burst.size() - 1);
            reassembled_q.insert(reassembled_q.size(), r);
        end
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reassemble(cur_word);
                sent_count++;
                if (sent_count % 32 == 0)
                    src_calm = ($urandom_range(0, 2) == 0);
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_wait > 0 || stim_q.size() == 0 ||
                    (stim_q[0].drain_first && reassembled_q.size() != 0))
                begin
                    if (src_wait > 0)
                        src_wait--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    cur_word = stim_q[0];
                    stim_q.delete(0);
                    s_tdata  <= {cur_word.read_count, cur_word.eof, cur_word.value,
                                 cur_word.index};
                    s_tuser  <= {cur_word.has_byte, bit'(cur_word.mode)};
                    s_tlast  <= cur_word.seg_last;
                    s_tvalid <= 1'b1;
                    src_wait = draw_wait(src_calm);
                end
            end
        end
    end

    // sink side and checking
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t act;
        out_word_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                act.valid = m_tuser;
                act.data  = m_tdata[7:0];
                act.eos   = m_tdata[8];
                act.held  = m_tdata[15:9];
                act.last  = m_tlast;
                if (reassembled_q.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected word: valid=%0b byte=%02h eos=%0b held=%0d last=%0b",
                                 act.valid, act.data, act.eos, act.held, act.last);
                end
                else
                begin
                    want = reassembled_q[0];
                    reassembled_q.delete(0);
                    if (act.valid !== want.valid || act.data !== want.data ||
                        act.eos !== want.eos || act.held !== want.held ||
                        act.last !== want.last)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch at word %0d: want valid=%0b byte=%02h eos=%0b %s",
                                     got_count, want.valid, want.data, want.eos,
                                     $sformatf("held=%0d last=%0b, got valid=%0b byte=%02h %s",
                                               want.held, want.last, act.valid, act.data,
                                               $sformatf("eos=%0b held=%0d last=%0b",
                                                         act.eos, act.held, act.last)));
                    end
                end
                got_count++;
                if (got_count % 32 == 0)
                    sink_calm = ($urandom_range(0, 2) == 0);
                sink_wait = draw_wait(sink_calm);
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    initial
    begin
        idx_t base;
        idx_t gen_read;
        idx_t at;
        int   stop_at;
        int   next_drain;
        int   len;
        int   n_seg;
        int   off;
        int   tmp;
        int   j;
        int   s;
        bit   tail_empty;
        bit   stream_end;
        bit   is_last;
        int   seg_at [CAPACITY];
        int   seg_len [CAPACITY];
        int   perm [CAPACITY];

        // directed: window edges, stale and far bytes, overwrite, clamped reads, end flag
        push_word(MODE_READ, '0, 0, 0, 0, 0, 64);
        push_word(MODE_SEG, 32'hFFFF_FFFF, 8'h3C, 1, 1, 1, 0);
        push_word(MODE_SEG, 32'd64, 8'h11, 1, 0, 0, 0);
        push_word(MODE_SEG, 32'd63, 8'hFF, 1, 0, 0, 0);
        push_word(MODE_SEG, 32'd63, 8'hA5, 1, 1, 0, 0);
        push_word(MODE_SEG, 32'd1, 8'h00, 1, 0, 0, 0);
        push_word(MODE_SEG, 32'h8000_0000, 8'h00, 0, 0, 1, 0);
        push_word(MODE_SEG, 32'hFFFF_FFFF, 8'h00, 0, 1, 1, 0);
        push_word(MODE_SEG, 32'd0, 8'h5A, 1, 1, 0, 0);
        push_word(MODE_SEG, 32'd0, 8'h77, 1, 1, 0, 0);
        push_word(MODE_READ, '0, 0, 0, 0, 0, 1);
        push_word(MODE_READ, '0, 0, 0, 0, 0, 10);
        push_word(MODE_SEG, 32'd67, 8'h00, 0, 1, 1, 0);
        push_word(MODE_SEG, 32'd65, 8'hC3, 1, 1, 1, 0);
        push_word(MODE_SEG, 32'd66, 8'h99, 1, 1, 0, 0);
        push_word(MODE_READ, '0, 0, 0, 0, 0, 0);

        // random: contiguous groups split into shuffled segments, reads keep the window open
        base       = 32'd2;
        gen_read   = 32'd2;
        stop_at    = planned + 400;
        next_drain = planned + 100;
        drain_next = 1'b1;
        while (planned < stop_at)
        begin
            // gen_read stays a lower bound of the real read point
            push_word(MODE_READ, '0, 0, 0, 0, 0, $urandom_range(base - gen_read, 64));
            gen_read = base;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 16);
            n_seg = 0;
            off   = 0;
            while (off < len)
            begin
                seg_at[n_seg]  = off;
                seg_len[n_seg] = $urandom_range(1, 8);
                if (seg_len[n_seg] > len - off)
                    seg_len[n_seg] = len - off;
                off += seg_len[n_seg];
                perm[n_seg] = n_seg;
                n_seg++;
            end
            for (int i = n_seg - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            for (int i = 0; i < n_seg; i++)
            begin
                s          = perm[i];
                tail_empty = ($urandom_range(0, 6) == 0);
                stream_end = (i == n_seg - 1) && ($urandom_range(0, 7) == 0);
                for (int k = 0; k < seg_len[s]; k++)
                begin
                    at      = base + seg_at[s] + k;
                    is_last = (k == seg_len[s] - 1) && !tail_empty;
                    push_word(MODE_SEG, at, $urandom_range(0, 255), 1, is_last,
                              is_last ? stream_end : bit'($urandom_range(0, 1)), 0);
                end
                if (tail_empty)
                    push_word(MODE_SEG, base + seg_at[s] + seg_len[s], 0, 0, 1, stream_end, 0);
                if ($urandom_range(0, 9) == 0)
                begin
                    case ($urandom_range(0, 4))
                        0: push_word(MODE_SEG, $urandom_range(0, base - 1),
                                     $urandom_range(0, 255), 1, 1, 0, 0);
                        1: push_word(MODE_SEG, $urandom, $urandom_range(0, 255), 1,
                                     bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)), 0);
                        2: push_word(MODE_SEG, base + $urandom_range(0, len - 1),
                                     $urandom_range(0, 255), 1, 1, 0, 0);
                        3: push_word(MODE_READ, '0, 0, 0, 0, 0, $urandom_range(0, 64));
                        default: push_word(MODE_SEG, $urandom, 0, 0, bit'($urandom_range(0, 1)),
                                           bit'($urandom_range(0, 1)), 0);
                    endcase
                end
            end
            base += len;
            if (planned >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain = planned + 100;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (reassembled_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
